// ===== design/wlc_pkg.sv =====
`timescale 1ns / 1ps

package wlc_pkg;

  localparam int CLS_W     = 2;
  localparam int THR_W     = 6;
  localparam int RATE_W    = 16;
  localparam int LEN_W     = 8;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CLS_W-1:0] CLS_ALNUM = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SPACE = 2'd1;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_PAGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_MIN   = 2'd2;

  localparam logic [THR_W-1:0]  THR_RST  = 6'd6;
  localparam logic [RATE_W-1:0] WPP_RST  = 16'd250;
  localparam logic [RATE_W-1:0] WPM_RST  = 16'd270;
  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_DELIVER
  } state_t;

  typedef enum logic [1:0] {
    OP_PCT,
    OP_PAGE,
    OP_MIN
  } op_t;

  typedef struct packed {
    logic             char_en;
    logic             flush;
    logic             clear;
    logic [CLS_W-1:0] cls;
  } tally_cmd_t;

endpackage

// ===== design/wlc_in_if.sv =====
`timescale 1ns / 1ps

interface wlc_in_if;
  import wlc_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [CLS_W-1:0] char_class;

  modport source (output valid, output action, output char_class, input ready);
  modport sink (input valid, input action, input char_class, output ready);
endinterface

// ===== design/wlc_out_if.sv =====
`timescale 1ns / 1ps

interface wlc_out_if #(
  parameter int COUNT_BITS = 24
);
  import wlc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] word_count;
  logic [COUNT_BITS-1:0] long_word_count;
  logic [COUNT_BITS-1:0] word_char_count;
  logic [PCT_W-1:0]      complex_percent;
  logic [COUNT_BITS-1:0] page_count;
  logic [COUNT_BITS-1:0] reading_minutes;

  modport source (
    output valid, output word_count, output long_word_count, output word_char_count,
    output complex_percent, output page_count, output reading_minutes, input ready
  );
  modport sink (
    input valid, input word_count, input long_word_count, input word_char_count,
    input complex_percent, input page_count, input reading_minutes, output ready
  );
endinterface

// ===== design/wlc_cfg_if.sv =====
`timescale 1ns / 1ps

interface wlc_cfg_if;
  import wlc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RATE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/word_and_long_word_counter_core.sv =====
`timescale 1ns / 1ps

// Counts words, long words and word characters in a stream of pre-classified
// characters and, on an end-of-text beat, reports the totals with the long-word
// percentage (rounded up), the page count and the reading minutes, then clears.
// A character beat is taken every cycle except while an end-of-text beat is worked
// on: that beat keeps the input stalled while the one restoring divider that serves
// all three quotients, retiring one quotient bit per cycle, works them out in turn;
// the beat's result turns valid as the input is released. The stall grows while an
// earlier result still waits in the output register. The finished result sits in
// that register, so character beats flow again while it waits to be taken.
// Write configuration only while no end-of-text beat is being worked on.
module word_and_long_word_counter_core #(
  parameter int COUNT_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  wlc_in_if.sink    in_bus,
  wlc_out_if.source out_bus,
  wlc_cfg_if.sink   cfg_bus
);
  import wlc_pkg::*;

  localparam int DVD_W = COUNT_BITS + PCT_W;
  localparam int DVS_W = (COUNT_BITS > RATE_W) ? COUNT_BITS : RATE_W;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [THR_W-1:0]  thr_r;
  logic [RATE_W-1:0] wpp_r;
  logic [RATE_W-1:0] wpm_r;

  logic [COUNT_BITS-1:0] words, long_words, chars;
  tally_cmd_t            cmd;

  logic                  in_fire;
  logic                  div_start;
  logic [DVD_W-1:0]      div_dvd;
  logic [DVS_W-1:0]      div_dvs;
  logic                  div_done;
  logic [DVD_W-1:0]      div_quo;

  logic [PCT_W-1:0]      pct_r;
  logic [COUNT_BITS-1:0] page_r;
  logic [COUNT_BITS-1:0] min_r;
  logic                  load;

  logic                  out_valid_r;
  logic [COUNT_BITS-1:0] out_words_r, out_long_r, out_chars_r, out_page_r, out_min_r;
  logic [PCT_W-1:0]      out_pct_r;

  // Configuration.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
      wpp_r <= WPP_RST;
      wpm_r <= WPM_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_THRESHOLD: thr_r <= cfg_bus.data[THR_W-1:0];
        CFG_PER_PAGE:  wpp_r <= cfg_bus.data;
        CFG_PER_MIN:   wpm_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_comb begin
    cmd.char_en = in_fire && (in_bus.action == ACT_CHAR);
    cmd.flush   = in_fire && (in_bus.action == ACT_END);
    cmd.clear   = load;
    cmd.cls     = in_bus.char_class;
  end

  wlc_tally #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tally (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .threshold  (thr_r),
    .words      (words),
    .long_words (long_words),
    .chars      (chars)
  );

  // Operand selection for the shared divider.
  always_comb begin
    case (op_r)
      OP_PCT: begin
        // Ceiling of 100 * long / words as (100 * long + words - 1) / words.
        div_dvd = DVD_W'(long_words) * DVD_W'(PCT_FULL) + DVD_W'(words) - DVD_W'(1);
        div_dvs = DVS_W'(words);
      end
      OP_PAGE: begin
        div_dvd = DVD_W'(words);
        div_dvs = DVS_W'(wpp_r);
      end
      OP_MIN: begin
        div_dvd = DVD_W'(words);
        div_dvs = DVS_W'(wpm_r);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  wlc_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_bus.action == ACT_END)) begin
          state_nxt = ST_START;
          op_nxt    = OP_PCT;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_nxt = ST_START;
          case (op_r)
            OP_PCT:  op_nxt = OP_PAGE;
            OP_PAGE: op_nxt = OP_MIN;
            default: state_nxt = ST_DELIVER;
          endcase
        end
      end
      ST_DELIVER: begin
        if (!out_valid_r || out_bus.ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_PCT;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Quotients; a zero divisor reports zero.
  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && div_done) begin
      case (op_r)
        OP_PCT: begin
          if (words == '0) begin
            pct_r <= '0;
          end else if (div_quo > DVD_W'(PCT_FULL)) begin
            pct_r <= PCT_FULL;
          end else begin
            pct_r <= div_quo[PCT_W-1:0];
          end
        end
        OP_PAGE: page_r <= (wpp_r == '0) ? '0 : div_quo[COUNT_BITS-1:0];
        default: min_r  <= (wpm_r == '0) ? '0 : div_quo[COUNT_BITS-1:0];
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_words_r <= words;
      out_long_r  <= long_words;
      out_chars_r <= chars;
      out_pct_r   <= pct_r;
      out_page_r  <= page_r;
      out_min_r   <= min_r;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.word_count      = out_words_r;
  assign out_bus.long_word_count = out_long_r;
  assign out_bus.word_char_count = out_chars_r;
  assign out_bus.complex_percent = out_pct_r;
  assign out_bus.page_count      = out_page_r;
  assign out_bus.reading_minutes = out_min_r;

endmodule

// ===== design/wlc_tally.sv =====
`timescale 1ns / 1ps

module wlc_tally #(
  parameter int COUNT_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wlc_pkg::tally_cmd_t        cmd,
  input  logic [wlc_pkg::THR_W-1:0]  threshold,
  output logic [COUNT_BITS-1:0]      words,
  output logic [COUNT_BITS-1:0]      long_words,
  output logic [COUNT_BITS-1:0]      chars
);
  import wlc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LEN_W-1:0]      LEN_MAX = {LEN_W{1'b1}};

  logic                  in_word_r, in_word_nxt;
  logic                  sep_r, sep_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [COUNT_BITS-1:0] words_r, words_nxt;
  logic [COUNT_BITS-1:0] long_r, long_nxt;
  logic [COUNT_BITS-1:0] chars_r, chars_nxt;

  logic [1:0]            add;
  logic [LEN_W:0]        len_sum;
  logic [COUNT_BITS:0]   chars_sum;
  logic                  close;

  always_comb begin
    // A pending separator is only counted once a letter or digit follows it.
    add       = (in_word_r && sep_r) ? 2'd2 : 2'd1;
    len_sum   = {1'b0, len_r} + (LEN_W + 1)'(add);
    chars_sum = {1'b0, chars_r} + (COUNT_BITS + 1)'(add);

    in_word_nxt = in_word_r;
    sep_nxt     = sep_r;
    len_nxt     = len_r;
    words_nxt   = words_r;
    long_nxt    = long_r;
    chars_nxt   = chars_r;
    close       = 1'b0;

    if (cmd.char_en) begin
      if (cmd.cls == CLS_ALNUM) begin
        len_nxt     = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
        chars_nxt   = chars_sum[COUNT_BITS] ? CNT_MAX : chars_sum[COUNT_BITS-1:0];
        in_word_nxt = 1'b1;
        sep_nxt     = 1'b0;
      end else if (in_word_r) begin
        if (cmd.cls == CLS_SPACE || sep_r) begin
          close = 1'b1;
        end else begin
          sep_nxt = 1'b1;
        end
      end
    end else if (cmd.flush) begin
      close = in_word_r;
    end

    if (close) begin
      words_nxt = (words_r == CNT_MAX) ? words_r : words_r + 1'b1;
      if (len_r > LEN_W'(threshold)) begin
        long_nxt = (long_r == CNT_MAX) ? long_r : long_r + 1'b1;
      end
      in_word_nxt = 1'b0;
      sep_nxt     = 1'b0;
      len_nxt     = '0;
    end

    if (cmd.clear) begin
      in_word_nxt = 1'b0;
      sep_nxt     = 1'b0;
      len_nxt     = '0;
      words_nxt   = '0;
      long_nxt    = '0;
      chars_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r <= 1'b0;
      sep_r     <= 1'b0;
      len_r     <= '0;
      words_r   <= '0;
      long_r    <= '0;
      chars_r   <= '0;
    end else begin
      in_word_r <= in_word_nxt;
      sep_r     <= sep_nxt;
      len_r     <= len_nxt;
      words_r   <= words_nxt;
      long_r    <= long_nxt;
      chars_r   <= chars_nxt;
    end
  end

  assign words      = words_r;
  assign long_words = long_r;
  assign chars      = chars_r;

endmodule

// ===== design/wlc_divider.sv =====
`timescale 1ns / 1ps

module wlc_divider #(
  parameter int DVD_W = 31,
  parameter int DVS_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  always_comb begin
    // Restoring division: the dividend shifts out of quo_r as quotient bits shift in.
    shifted = {rem_r, quo_r[DVD_W-1]};
    fits    = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
